// ===== rtl/blhsv_pkg.sv =====
// blhsv_pkg: shared constants, types and helper functions of the bar level color pipeline
// no dependencies; used by every module under rtl except blhsv_checker
`default_nettype none

package blhsv_pkg;

    // fixed point, unsigned, scale 65536
    localparam logic [16:0] FxOne    = 17'd65536;
    localparam logic [15:0] FxSat    = 16'd55706;
    localparam logic [16:0] FxVbase  = 17'd22938;
    localparam logic [15:0] FxVspan  = 16'd42598;

    // hue times six for the fixed hue and for the saturated hue
    localparam logic [18:0] H6Fixed  = 19'd216270;
    localparam logic [18:0] H6Full   = 19'd393216;

    // hue divider shape: quotient bits, bits per stage
    localparam int DivSteps      = 19;
    localparam int StepsPerStage = 4;

    // register stages from transfer to result
    localparam int PipeDepth     = 7;

    // hsv sectors
    localparam logic [2:0] Sect0 = 3'd0;
    localparam logic [2:0] Sect1 = 3'd1;
    localparam logic [2:0] Sect2 = 3'd2;
    localparam logic [2:0] Sect3 = 3'd3;
    localparam logic [2:0] Sect4 = 3'd4;

    // state of the long division carried between hue stages
    typedef struct packed {
        logic [7:0]          d;
        logic [7:0]          rem;
        logic [DivSteps-1:0] num;
        logic [DivSteps-1:0] q;
        logic                few;
        logic                past;
    } t_div_st;

    // operands handed from hue and chroma paths to the mixer
    typedef struct packed {
        logic [15:0] c;
        logic [16:0] m;
        logic [18:0] h6;
        logic [16:0] t;
    } t_mix_in;

    // up to StepsPerStage restoring division steps, starting at quotient bit base
    function automatic t_div_st div_pass(input t_div_st s_in, input int base);
        t_div_st    s;
        logic [8:0] rem9;
        s = s_in;
        for (int i = 0; i < StepsPerStage; i++) begin
            if (base + i < DivSteps) begin
                rem9  = {s.rem, s.num[DivSteps-1]};
                s.num = {s.num[DivSteps-2:0], 1'b0};
                if (rem9 >= {1'b0, s.d}) begin
                    s.rem = 8'(rem9 - {1'b0, s.d});
                    s.q   = {s.q[DivSteps-2:0], 1'b1};
                end else begin
                    s.rem = rem9[7:0];
                    s.q   = {s.q[DivSteps-2:0], 1'b0};
                end
            end
        end
        return s;
    endfunction

    // channel 0..65536 scaled by 255, truncated to 8 bits
    function automatic logic [7:0] chan8(input logic [16:0] ch);
        logic [24:0] p;
        p = {ch, 8'b0} - {8'b0, ch};
        return p[23:16];
    endfunction

endpackage

`default_nettype wire

// ===== rtl/blhsv_hue.sv =====
// blhsv_hue: five stage pipelined hue divider with few-bars and past-end cases
// depends on blhsv_pkg
`default_nettype none

module blhsv_hue (
    input  wire logic        i_clk,
    input  wire logic [7:0]  i_bar_index,
    input  wire logic [7:0]  i_bar_count,
    output logic [18:0]      o_h6,
    output logic [16:0]      o_t
);

    blhsv_pkg::t_div_st s0;
    blhsv_pkg::t_div_st fin;
    blhsv_pkg::t_div_st r_st [4];
    logic [10:0]        idx6;
    logic [18:0]        n_h6;
    logic [16:0]        f;
    logic [16:0]        n_t;
    logic [18:0]        r_h6;
    logic [16:0]        r_t;

    // divisor, dividend and special case flags
    always_comb begin
        idx6    = {3'b0, i_bar_index} * 11'd6;
        s0.d    = i_bar_count - 8'd1;
        s0.rem  = idx6[10:3];
        s0.num  = {idx6[2:0], 16'b0};
        s0.q    = '0;
        s0.few  = (i_bar_count <= 8'd1);
        s0.past = (i_bar_index >= s0.d);
    end

    // division stages, four quotient bits each
    always_ff @(posedge i_clk) begin
        r_st[0] <= blhsv_pkg::div_pass(s0, 0);
    end

    for (genvar k = 1; k < 4; k++) begin : g_div
        always_ff @(posedge i_clk) begin
            r_st[k] <= blhsv_pkg::div_pass(r_st[k-1], k * blhsv_pkg::StepsPerStage);
        end
    end

    // last quotient bits, hue select and triangle distance
    always_comb begin
        fin = blhsv_pkg::div_pass(r_st[3], 4 * blhsv_pkg::StepsPerStage);
        priority if (fin.few) begin
            n_h6 = blhsv_pkg::H6Fixed;
        end else if (fin.past) begin
            n_h6 = blhsv_pkg::H6Full;
        end else begin
            n_h6 = fin.q;
        end
        f = n_h6[16:0];
        if (f >= blhsv_pkg::FxOne) begin
            n_t = f - blhsv_pkg::FxOne;
        end else begin
            n_t = blhsv_pkg::FxOne - f;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h6 <= n_h6;
        r_t  <= n_t;
    end

    assign o_h6 = r_h6;
    assign o_t  = r_t;

endmodule

`default_nettype wire

// ===== rtl/blhsv_chroma.sv =====
// blhsv_chroma: value, chroma and offset from the bar level, five register stages
// depends on blhsv_pkg
`default_nettype none

module blhsv_chroma (
    input  wire logic        i_clk,
    input  wire logic [15:0] i_level,
    output logic [15:0]      o_c,
    output logic [16:0]      o_m
);

    logic [16:0] n_lvl;
    logic [32:0] n_pv;
    logic [16:0] n_val;
    logic [32:0] n_pc;
    logic [16:0] r_val;
    logic [16:0] r_val2;
    logic [15:0] r_c2;
    logic [15:0] r_c3;
    logic [16:0] r_m3;
    logic [15:0] r_c4;
    logic [16:0] r_m4;
    logic [15:0] r_c5;
    logic [16:0] r_m5;

    // value = base + span * level
    always_comb begin
        n_lvl = {1'b0, i_level} + 17'(i_level[15]);
        n_pv  = 33'(blhsv_pkg::FxVspan) * 33'(n_lvl);
        n_val = blhsv_pkg::FxVbase + 17'(n_pv[32:16]);
        n_pc  = 33'(r_val) * 33'(blhsv_pkg::FxSat);
    end

    // chroma, then offset, then delay to meet the hue path
    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_val2 <= r_val;
        r_c2   <= n_pc[31:16];
        r_c3   <= r_c2;
        r_m3   <= r_val2 - {1'b0, r_c2};
        r_c4   <= r_c3;
        r_m4   <= r_m3;
        r_c5   <= r_c4;
        r_m5   <= r_m4;
    end

    assign o_c = r_c5;
    assign o_m = r_m5;

endmodule

`default_nettype wire

// ===== rtl/blhsv_mix.sv =====
// blhsv_mix: secondary component, sector select, 8-bit scaling and 5-6-5 packing
// depends on blhsv_pkg
`default_nettype none

module blhsv_mix (
    input  wire logic               i_clk,
    input  wire blhsv_pkg::t_mix_in i_mix,
    output logic [15:0]             o_pixel_color
);

    logic [32:0] n_px;
    logic [15:0] r_x;
    logic [15:0] r_c;
    logic [16:0] r_m;
    logic [2:0]  r_sec;
    logic [15:0] red;
    logic [15:0] grn;
    logic [15:0] blu;
    logic [7:0]  ri;
    logic [7:0]  gi;
    logic [7:0]  bi;
    logic [15:0] r_pixel;

    // x = c * (1 - t)
    assign n_px = 33'(i_mix.c) * 33'(blhsv_pkg::FxOne - i_mix.t);

    always_ff @(posedge i_clk) begin
        r_x   <= n_px[31:16];
        r_c   <= i_mix.c;
        r_m   <= i_mix.m;
        r_sec <= i_mix.h6[18:16];
    end

    // six sector rule, high sectors share the last case
    always_comb begin
        red = '0;
        grn = '0;
        blu = '0;
        unique case (r_sec)
            blhsv_pkg::Sect0: begin red = r_c; grn = r_x; end
            blhsv_pkg::Sect1: begin red = r_x; grn = r_c; end
            blhsv_pkg::Sect2: begin grn = r_c; blu = r_x; end
            blhsv_pkg::Sect3: begin grn = r_x; blu = r_c; end
            blhsv_pkg::Sect4: begin red = r_x; blu = r_c; end
            default:          begin red = r_c; blu = r_x; end
        endcase
        ri = blhsv_pkg::chan8({1'b0, red} + r_m);
        gi = blhsv_pkg::chan8({1'b0, grn} + r_m);
        bi = blhsv_pkg::chan8({1'b0, blu} + r_m);
    end

    // packed output register
    always_ff @(posedge i_clk) begin
        r_pixel <= {ri[7:3], gi[7:2], bi[7:3]};
    end

    assign o_pixel_color = r_pixel;

endmodule

`default_nettype wire

// ===== rtl/bar_level_hsv_to_rgb565.sv =====
// bar_level_hsv_to_rgb565: top level of the bar color pipeline
// depends on blhsv_pkg, blhsv_hue, blhsv_chroma, blhsv_mix
//
// Usage
//   An item (level, bar index, bar count) is taken on each rising edge where
//   start is high and busy is low. busy is low whenever reset is released, so
//   a new item may be offered on every clock.
//   Each item gives one RGB565 color on o_pixel_color, marked by o_strobe for
//   exactly one cycle. Colors appear in item order; throughput is one item per
//   cycle out of reset.
//   Pipeline depth is set by the hue divider: 19 quotient bits at four bits a
//   stage take five stages, followed by one multiply stage for the secondary
//   component and one stage for scaling and packing.
//   The receiver cannot hold results off; o_strobe carries no backpressure.
//   Synchronous reset (i_rst_n low) clears all valid bits: items in flight
//   are dropped and busy stays high until reset is released.
`default_nettype none

module bar_level_hsv_to_rgb565 (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic [15:0] i_level,
    input  wire logic [7:0]  i_bar_index,
    input  wire logic [7:0]  i_bar_count,
    output logic             o_strobe,
    output logic [15:0]      o_pixel_color
);

    logic               [blhsv_pkg::PipeDepth-1:0] r_vld;
    logic               [blhsv_pkg::PipeDepth-1:0] n_vld;
    logic               [18:0]      h6;
    logic               [16:0]      t;
    logic               [15:0]      c;
    logic               [16:0]      m;
    blhsv_pkg::t_mix_in             mix;

    assign busy = ~i_rst_n;

    // hue path
    blhsv_hue u_hue (
        .i_clk       (i_clk),
        .i_bar_index (i_bar_index),
        .i_bar_count (i_bar_count),
        .o_h6        (h6),
        .o_t         (t)
    );

    // value and chroma path
    blhsv_chroma u_chroma (
        .i_clk   (i_clk),
        .i_level (i_level),
        .o_c     (c),
        .o_m     (m)
    );

    always_comb begin
        mix.c  = c;
        mix.m  = m;
        mix.h6 = h6;
        mix.t  = t;
    end

    // color mixing and packing
    blhsv_mix u_mix (
        .i_clk         (i_clk),
        .i_mix         (mix),
        .o_pixel_color (o_pixel_color)
    );

    // valid bits follow each transfer down the pipeline
    assign n_vld = {r_vld[blhsv_pkg::PipeDepth-2:0], start & ~busy};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_strobe = r_vld[blhsv_pkg::PipeDepth-1];

endmodule

`default_nettype wire

// ===== rtl/blhsv_checker.sv =====
// blhsv_checker: port level assertions for the bar color pipeline
// depends on bar_level_hsv_to_rgb565 ports only; bound to the top level below
`default_nettype none

module blhsv_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic [15:0] i_level,
    input wire logic [7:0]  i_bar_index,
    input wire logic [7:0]  i_bar_count,
    input wire logic        o_strobe,
    input wire logic [15:0] o_pixel_color
);

    // every result comes from a matching earlier transfer
    a_strobe_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(start && !busy, 7))
        else $error("strobe without a matching transfer");

    // every transfer gives a result on o_strobe
    a_strobe_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##7 o_strobe)
        else $error("transfer without a result");

    // out of reset the block always takes items
    a_no_busy: assert property (@(posedge i_clk)
        i_rst_n |-> !busy)
        else $error("busy outside reset");

    // reset flushes the pipeline
    a_flush: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_strobe)
        else $error("strobe right after reset");

    // equal back to back items give equal colors
    a_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && $past(o_strobe)
         && $past(i_level, 7) == $past(i_level, 8)
         && $past(i_bar_index, 7) == $past(i_bar_index, 8)
         && $past(i_bar_count, 7) == $past(i_bar_count, 8))
        |-> o_pixel_color == $past(o_pixel_color))
        else $error("same item gave a different color");

endmodule

bind bar_level_hsv_to_rgb565 blhsv_checker u_chk (.*);

`default_nettype wire
